// ===== src/snet_pkg.sv =====
// Package: shared types, constants and the tanh table of the sparse net evaluator.
`timescale 1ns / 1ps
package snet_pkg;
	localparam int MAX_NEURONS = 64;
	localparam int MAX_LINKS   = 256;
	localparam int MAX_OUTPUTS = 16;

	localparam int NEURON_AW = $clog2(MAX_NEURONS);
	localparam int LINK_AW   = $clog2(MAX_LINKS);
	localparam int LCNT_W    = $clog2(MAX_LINKS + 1);
	localparam int OUTK_W    = $clog2(MAX_OUTPUTS + 1);
	localparam int CNT_W     = $clog2(MAX_LINKS + MAX_NEURONS + MAX_OUTPUTS + 8);
	localparam int ACC_W     = 32 + LINK_AW;
	localparam int OIDX_W    = 8;

	localparam int GENE_DRAIN = 3;
	localparam int WB_DRAIN   = 2;

	localparam logic signed [15:0] Q_ONE = 16'sd4096;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_WRITE  = 2'd2,
		OP_EVAL   = 2'd3
	} opcode_t;

	localparam logic CFG_INPUT_COUNT  = 1'b0;
	localparam logic CFG_OUTPUT_COUNT = 1'b1;

	typedef struct packed {
		opcode_t            opcode;
		logic [5:0]         source_index;
		logic [5:0]         target_index;
		logic               gene_on;
		logic signed [15:0] value;
	} item_t;

	typedef struct packed {
		logic signed [15:0] out_value;
		logic               last;
	} result_t;

	typedef struct packed {
		logic [5:0]         src;
		logic [5:0]         tgt;
		logic signed [15:0] weight;
		logic               on;
	} gene_t;

	typedef struct packed {
		logic                 load;
		logic                 clr_driven;
		logic                 gene_rd;
		logic [LINK_AW-1:0]   gene_addr;
		logic                 wb_rd;
		logic [NEURON_AW-1:0] wb_addr;
		logic                 out_rd;
		logic [OUTK_W-1:0]    out_k;
		logic                 out_last;
	} cmd_t;

	typedef struct packed {
		logic [LCNT_W-1:0] link_count;
		logic [OUTK_W-1:0] out_count;
	} stat_t;

	function automatic logic [12:0] tanh_knot(input logic [4:0] k);
		logic [12:0] r;
		unique case (k)
			5'd0: r = 13'd0;
			5'd1: r = 13'd1893;
			5'd2: r = 13'd3119;
			5'd3: r = 13'd3707;
			5'd4: r = 13'd3949;
			5'd5: r = 13'd4041;
			5'd6: r = 13'd4076;
			5'd7: r = 13'd4089;
			5'd8: r = 13'd4093;
			5'd9: r = 13'd4095;
			default: r = 13'd4096;
		endcase
		return r;
	endfunction

	function automatic logic signed [15:0] tanh_pwl(input logic signed [15:0] x);
		logic [15:0] a;
		logic [4:0]  seg;
		logic [10:0] frac;
		logic [12:0] k0;
		logic [12:0] k1;
		logic [10:0] d;
		logic [21:0] p;
		logic [12:0] y;
		a    = x[15] ? 16'(-x) : 16'(x);
		seg  = a[15:11];
		frac = a[10:0];
		k0   = tanh_knot(seg);
		k1   = tanh_knot(seg + 5'd1);
		d    = 11'(k1 - k0);
		p    = 22'(d) * 22'(frac) + 22'd1024;
		if (seg >= 5'd16) begin
			y = 13'd4096;
		end else begin
			y = k0 + 13'(p >> 11);
		end
		return x[15] ? -$signed({3'b000, y}) : $signed({3'b000, y});
	endfunction
endpackage

// ===== src/snet_ctrl.sv =====
// Controller: sequences gene walk, write-back and readout of an evaluation.
`timescale 1ns / 1ps
module snet_ctrl import snet_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  item_t item,
	input  stat_t stat,
	output logic  busy,
	output cmd_t  cmd
);
	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_GENE  = 4'b0010,
		S_WBACK = 4'b0100,
		S_OUT   = 4'b1000
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] lcnt;
	logic [CNT_W-1:0] ocnt;

	assign lcnt = CNT_W'(stat.link_count);
	assign ocnt = CNT_W'(stat.out_count);
	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd            = '0;
		cmd.load       = start && (state_q == S_IDLE);
		cmd.clr_driven = cmd.load && (item.opcode == OP_EVAL);
		cmd.gene_rd    = (state_q == S_GENE) && (cnt_q < lcnt);
		cmd.gene_addr  = cnt_q[LINK_AW-1:0];
		cmd.wb_rd      = (state_q == S_WBACK) && (cnt_q < CNT_W'(MAX_NEURONS));
		cmd.wb_addr    = cnt_q[NEURON_AW-1:0];
		cmd.out_rd     = (state_q == S_OUT) && (cnt_q < ocnt);
		cmd.out_k      = cnt_q[OUTK_W-1:0];
		cmd.out_last   = (cnt_q + CNT_W'(1)) == ocnt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (cmd.clr_driven) state_q <= S_GENE;
				end
				S_GENE: begin
					if (cnt_q >= lcnt + CNT_W'(GENE_DRAIN)) begin
						state_q <= S_WBACK;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				S_WBACK: begin
					if (cnt_q >= CNT_W'(MAX_NEURONS + WB_DRAIN)) begin
						state_q <= S_OUT;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				S_OUT: begin
					if (cnt_q >= ocnt) begin
						state_q <= S_IDLE;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
					cnt_q   <= '0;
				end
			endcase
		end
	end
endmodule

// ===== src/snet_datapath.sv =====
// Datapath: gene table, neuron and sum memories, multiply-accumulate and tanh.
`timescale 1ns / 1ps
module snet_datapath import snet_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  item_t      item,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [6:0] cfg_data,
	input  cmd_t       cmd,
	output stat_t      stat,
	output logic       result_valid,
	output result_t    result
);
	localparam logic signed [ACC_W-13:0] SAT_HI = 32767;
	localparam logic signed [ACC_W-13:0] SAT_LO = -32768;

	logic [6:0]        input_count_q;
	logic [4:0]        output_count_q;
	logic [LCNT_W-1:0] link_count_q;

	gene_t              gene_mem [MAX_LINKS];
	logic signed [15:0] neuron_mem [MAX_NEURONS];
	logic [MAX_NEURONS-1:0] nvalid_q;
	logic signed [ACC_W-1:0] acc_mem [MAX_NEURONS];
	logic [MAX_NEURONS-1:0] driven_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_count_q  <= 7'd1;
			output_count_q <= 5'd1;
		end else if (cfg_we) begin
			if (cfg_index == CFG_INPUT_COUNT) input_count_q <= cfg_data;
			if (cfg_index == CFG_OUTPUT_COUNT) output_count_q <= cfg_data[4:0];
		end
	end

	assign stat.link_count = link_count_q;
	assign stat.out_count  = (int'(output_count_q) > MAX_OUTPUTS) ?
		OUTK_W'(MAX_OUTPUTS) : OUTK_W'(output_count_q);

	// gene table
	logic do_append;
	assign do_append = cmd.load && (item.opcode == OP_APPEND)
		&& (int'(link_count_q) < MAX_LINKS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_count_q <= '0;
		end else if (cmd.load && (item.opcode == OP_CLEAR)) begin
			link_count_q <= '0;
		end else if (do_append) begin
			link_count_q <= link_count_q + LCNT_W'(1);
		end
	end

	gene_t gene_s1;
	logic  gv_s1;
	always_ff @(posedge clk) begin
		if (do_append) begin
			gene_mem[link_count_q[LINK_AW-1:0]] <= '{src: item.source_index,
				tgt: item.target_index, weight: item.value, on: item.gene_on};
		end
		gene_s1 <= gene_mem[cmd.gene_addr];
	end

	// stage 1: filter, read neuron and partial sum
	logic use_s1;
	assign use_s1 = gv_s1 && gene_s1.on && (int'(gene_s1.src) < MAX_NEURONS)
		&& (int'(gene_s1.tgt) < MAX_NEURONS);

	logic [OIDX_W-1:0]    out_idx;
	logic                 out_in;
	logic [NEURON_AW-1:0] n_raddr;
	logic [NEURON_AW-1:0] a_raddr;
	assign out_idx = OIDX_W'(input_count_q) + OIDX_W'(cmd.out_k);
	assign out_in  = int'(out_idx) < MAX_NEURONS;
	assign n_raddr = cmd.out_rd ? out_idx[NEURON_AW-1:0] : gene_s1.src[NEURON_AW-1:0];
	assign a_raddr = cmd.wb_rd ? cmd.wb_addr : gene_s1.tgt[NEURON_AW-1:0];

	logic signed [15:0]      nrd_q;
	logic                    nvld_q;
	logic signed [ACC_W-1:0] acc_rd_q;

	// write-back stage 2 signals, declared ahead of the neuron write port
	logic                    wv_w2;
	logic                    wd_w2;
	logic [NEURON_AW-1:0]    wn_w2;
	logic signed [15:0]      rs_w2;
	logic                    bias_hit;
	logic                    wb_we;
	logic signed [15:0]      wb_val;

	assign bias_hit = (input_count_q != 7'd0) && (int'(input_count_q) <= MAX_NEURONS)
		&& (OIDX_W'(wn_w2) == OIDX_W'(input_count_q) - OIDX_W'(1));
	assign wb_we    = wv_w2 && (wd_w2 || bias_hit);
	assign wb_val   = wd_w2 ? tanh_pwl(rs_w2) : Q_ONE;

	logic                 host_we;
	logic                 n_we;
	logic [NEURON_AW-1:0] n_waddr;
	logic signed [15:0]   n_wdata;
	assign host_we = cmd.load && (item.opcode == OP_WRITE)
		&& (int'(item.source_index) < MAX_NEURONS);
	assign n_we    = host_we || wb_we;
	assign n_waddr = host_we ? item.source_index[NEURON_AW-1:0] : wn_w2;
	assign n_wdata = host_we ? item.value : wb_val;

	always_ff @(posedge clk) begin
		if (n_we) neuron_mem[n_waddr] <= n_wdata;
		nrd_q <= neuron_mem[n_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nvalid_q <= '0;
			nvld_q   <= 1'b0;
		end else begin
			if (n_we) nvalid_q[n_waddr] <= 1'b1;
			nvld_q <= nvalid_q[n_raddr];
		end
	end

	// stage 2: multiply
	logic                 v_s2;
	logic [NEURON_AW-1:0] tgt_s2;
	logic signed [15:0]   w_s2;
	logic signed [15:0]   nval_s2;
	assign nval_s2 = nvld_q ? nrd_q : 16'sd0;

	logic                    v_s3;
	logic [NEURON_AW-1:0]    tgt_s3;
	logic signed [31:0]      prod_s3;
	logic signed [ACC_W-1:0] old_s3;

	always_ff @(posedge clk) begin
		tgt_s2  <= gene_s1.tgt[NEURON_AW-1:0];
		w_s2    <= gene_s1.weight;
		tgt_s3  <= tgt_s2;
		prod_s3 <= w_s2 * nval_s2;
		old_s3  <= acc_rd_q;
	end

	// stage 3: accumulate with forwarding from the two previous writes
	logic                    fv1_q;
	logic                    fv2_q;
	logic [NEURON_AW-1:0]    ft1_q;
	logic [NEURON_AW-1:0]    ft2_q;
	logic signed [ACC_W-1:0] fs1_q;
	logic signed [ACC_W-1:0] fs2_q;
	logic signed [ACC_W-1:0] base_s3;
	logic signed [ACC_W-1:0] sum_s3;

	always_comb begin
		priority if (fv1_q && (ft1_q == tgt_s3)) begin
			base_s3 = fs1_q;
		end else if (fv2_q && (ft2_q == tgt_s3)) begin
			base_s3 = fs2_q;
		end else if (driven_q[tgt_s3]) begin
			base_s3 = old_s3;
		end else begin
			base_s3 = '0;
		end
	end
	assign sum_s3 = base_s3 + ACC_W'(prod_s3);

	always_ff @(posedge clk) begin
		if (v_s3) acc_mem[tgt_s3] <= sum_s3;
		acc_rd_q <= acc_mem[a_raddr];
		ft1_q    <= tgt_s3;
		fs1_q    <= sum_s3;
		ft2_q    <= ft1_q;
		fs2_q    <= fs1_q;
	end

	// write-back stage 1: round and saturate
	logic                    wv_w1;
	logic                    wd_w1;
	logic [NEURON_AW-1:0]    wn_w1;
	logic signed [ACC_W:0]   rnd_w1;
	logic signed [ACC_W-13:0] shr_w1;
	logic signed [15:0]      sat_w1;

	assign rnd_w1 = (ACC_W + 1)'(acc_rd_q) + (ACC_W + 1)'(2048);
	assign shr_w1 = rnd_w1[ACC_W-1:12];
	always_comb begin
		priority if (shr_w1 > SAT_HI) begin
			sat_w1 = 16'sd32767;
		end else if (shr_w1 < SAT_LO) begin
			sat_w1 = -16'sd32768;
		end else begin
			sat_w1 = shr_w1[15:0];
		end
	end

	always_ff @(posedge clk) begin
		wn_w1 <= cmd.wb_addr;
		wd_w1 <= driven_q[cmd.wb_addr];
		wn_w2 <= wn_w1;
		wd_w2 <= wd_w1;
		rs_w2 <= sat_w1;
	end

	// readout
	logic    ov_o1;
	logic    oin_o1;
	logic    olast_o1;
	result_t result_q;
	logic    result_valid_q;

	always_ff @(posedge clk) begin
		oin_o1   <= out_in;
		olast_o1 <= cmd.out_last;
		result_q <= '{out_value: (oin_o1 && nvld_q) ? nrd_q : 16'sd0, last: olast_o1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gv_s1          <= 1'b0;
			v_s2           <= 1'b0;
			v_s3           <= 1'b0;
			fv1_q          <= 1'b0;
			fv2_q          <= 1'b0;
			driven_q       <= '0;
			wv_w1          <= 1'b0;
			wv_w2          <= 1'b0;
			ov_o1          <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			gv_s1 <= cmd.gene_rd;
			v_s2  <= use_s1;
			v_s3  <= v_s2;
			fv1_q <= v_s3;
			fv2_q <= fv1_q;
			if (cmd.clr_driven) begin
				driven_q <= '0;
			end else if (v_s3) begin
				driven_q[tgt_s3] <= 1'b1;
			end
			wv_w1          <= cmd.wb_rd;
			wv_w2          <= wv_w1;
			ov_o1          <= cmd.out_rd;
			result_valid_q <= ov_o1;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;
endmodule

// ===== src/sparse_net_one_step_eval_core.sv =====
// Top level of the sparse net one-step evaluator.
//
// Usage: drive item and raise start; an item transfers at a clock edge with
// start high and busy low. Clear, append and neuron write leave busy low.
// An evaluate raises busy and runs three phases: a gene walk through a
// pipelined multiply-accumulate (one gene per cycle from the gene table
// port), a write-back through round, saturate and tanh of every driven
// neuron, with the bias neuron set to one if undriven (one neuron per cycle
// from the sum memory port), and a readout of the output neurons (one per
// cycle from the neuron memory port). The last result of an evaluation comes
// out in the cycle in which busy drops, so the next item may follow. Results
// appear on result with result_valid high for one cycle each, in neuron
// order, the final one marked by last; the receiver cannot stall.
// Configuration writes through cfg_we, cfg_index and cfg_data take effect
// at once; the user must make them only while busy is low, and the block
// does not enforce this.
// Reset clears the gene count, neuron values and the configuration to 1.
`timescale 1ns / 1ps
module sparse_net_one_step_eval_core import snet_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  item_t      item,
	output logic       busy,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [6:0] cfg_data,
	output logic       result_valid,
	output result_t    result
);
	cmd_t  cmd;
	stat_t stat;

	snet_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	snet_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.stat         (stat),
		.result_valid (result_valid),
		.result       (result)
	);
endmodule

// ===== src/snet_checker.sv =====
// Checker: port-level properties of the evaluator, bound to the top level.
`timescale 1ns / 1ps
module snet_checker import snet_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input item_t   item,
	input logic    busy,
	input logic    result_valid,
	input result_t result
);
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (item.opcode == OP_EVAL) |=> busy)
		else $error("evaluate transfer did not raise busy");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (item.opcode != OP_EVAL) |=> !busy)
		else $error("load transfer raised busy");

	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |=> result_valid)
		else $error("gap inside a result burst");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !busy |-> result.last)
		else $error("result outside an evaluation");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !$past(busy) |-> !result_valid)
		else $error("result while idle");
endmodule

bind sparse_net_one_step_eval_core snet_checker u_snet_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.item         (item),
	.busy         (busy),
	.result_valid (result_valid),
	.result       (result)
);

// ===== test/tb.sv =====
// Testbench: directed and random checking of the sparse net one-step evaluator.
`timescale 1ns / 1ps

class eval_scoreboard;
	logic [6:0]         n_in;
	logic [4:0]         n_out;
	logic [5:0]         g_src [snet_pkg::MAX_LINKS];
	logic [5:0]         g_tgt [snet_pkg::MAX_LINKS];
	logic signed [15:0] g_wt [snet_pkg::MAX_LINKS];
	logic               g_on [snet_pkg::MAX_LINKS];
	int                 g_count;
	logic signed [15:0] neuron [snet_pkg::MAX_NEURONS];
	snet_pkg::result_t  pending [$];
	int                 errors;
	int                 results_seen;
	int                 evals;

	function new();
		n_in = 1;
		n_out = 1;
		g_count = 0;
		errors = 0;
		results_seen = 0;
		evals = 0;
		foreach (neuron[i]) neuron[i] = 0;
	endfunction

	function automatic int knot(int k);
		int t [17] = '{0, 1893, 3119, 3707, 3949, 4041, 4076, 4089, 4093,
			4095, 4096, 4096, 4096, 4096, 4096, 4096, 4096};
		return t[k];
	endfunction

	function automatic int squash(longint acc);
		longint r;
		int     a;
		int     seg;
		int     y;
		r = (acc + 2048) >>> 12;
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		a = (r < 0) ? -int'(r) : int'(r);
		seg = a >> 11;
		if (seg >= 16) y = 4096;
		else y = knot(seg) + (((knot(seg + 1) - knot(seg)) * (a & 2047) + 1024) >>> 11);
		return (r < 0) ? -y : y;
	endfunction

	function void set_cfg(logic idx, logic [6:0] d);
		if (idx == snet_pkg::CFG_INPUT_COUNT) n_in = d;
		else n_out = d[4:0];
	endfunction

	function void note_item(snet_pkg::item_t it);
		logic signed [15:0] snap [snet_pkg::MAX_NEURONS];
		longint             acc [snet_pkg::MAX_NEURONS];
		bit                 drv [snet_pkg::MAX_NEURONS];
		int                 n;
		int                 idx;
		snet_pkg::result_t  r;
		case (it.opcode)
			snet_pkg::OP_CLEAR: g_count = 0;
			snet_pkg::OP_APPEND: begin
				if (g_count < snet_pkg::MAX_LINKS) begin
					g_src[g_count] = it.source_index;
					g_tgt[g_count] = it.target_index;
					g_wt[g_count] = it.value;
					g_on[g_count] = it.gene_on;
					g_count++;
				end
			end
			snet_pkg::OP_WRITE: neuron[it.source_index] = it.value;
			default: begin
				evals++;
				foreach (neuron[i]) begin
					snap[i] = neuron[i];
					acc[i] = 0;
					drv[i] = 0;
				end
				if (n_in >= 1 && n_in <= snet_pkg::MAX_NEURONS) neuron[n_in - 1] = 16'sd4096;
				for (int i = 0; i < g_count; i++) begin
					if (g_on[i]) begin
						acc[g_tgt[i]] += longint'(g_wt[i]) * longint'(snap[g_src[i]]);
						drv[g_tgt[i]] = 1;
					end
				end
				foreach (neuron[i]) if (drv[i]) neuron[i] = 16'(squash(acc[i]));
				n = (n_out > snet_pkg::MAX_OUTPUTS) ? snet_pkg::MAX_OUTPUTS : n_out;
				for (int k = 0; k < n; k++) begin
					idx = n_in + k;
					r.out_value = (idx < snet_pkg::MAX_NEURONS) ? neuron[idx] : 16'sd0;
					r.last = (k + 1 == n);
					pending = {pending, r};
				end
			end
		endcase
	endfunction

	function void check_result(snet_pkg::result_t got);
		snet_pkg::result_t want;
		results_seen++;
		if (pending.size() == 0) begin
			errors++;
			if (errors <= 10) $display("unexpected result value=%0d last=%0b", got.out_value, got.last);
			return;
		end
		want = pending.pop_front();
		if (got !== want) begin
			errors++;
			if (errors <= 10)
				$display("mismatch: expected value=%0d last=%0b, got value=%0d last=%0b",
					want.out_value, want.last, got.out_value, got.last);
		end
	endfunction
endclass

module tb;
	import snet_pkg::*;

	logic    clk = 0;
	logic    arst_n = 0;
	logic    start = 0;
	item_t   item = '0;
	logic    busy;
	logic    cfg_we = 0;
	logic    cfg_index = 0;
	logic [6:0] cfg_data = 0;
	logic    result_valid;
	result_t result;

	eval_scoreboard sb;
	int      idle_pct;
	longint  cycles = 0;

	sparse_net_one_step_eval_core u_dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("** sparse_net_one_step_eval_core: FAILED **");
			$finish;
		end
	end

	always @(posedge clk) if (arst_n && result_valid) sb.check_result(result);

	task automatic send_item(item_t it);
		while ($urandom_range(99) < idle_pct) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		item <= it;
		do @(posedge clk); while (busy);
		sb.note_item(it);
	endtask

	task automatic drain();
		start <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_cfg(logic idx, logic [6:0] d);
		drain();
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		sb.set_cfg(idx, d);
		cfg_we <= 0;
	endtask

	function automatic item_t mk(opcode_t op, int s, int t, bit on, int v);
		item_t it;
		it.opcode = op;
		it.source_index = 6'(s);
		it.target_index = 6'(t);
		it.gene_on = on;
		it.value = 16'(v);
		return it;
	endfunction

	function automatic item_t rand_item(int n_in);
		int     r;
		opcode_t op;
		r = $urandom_range(99);
		op = r < 8 ? OP_CLEAR : r < 55 ? OP_APPEND : r < 80 ? OP_WRITE : OP_EVAL;
		return mk(op, $urandom_range(63),
			$urandom_range(3) == 0 ? $urandom_range(63) : n_in + $urandom_range(7) % 64,
			$urandom_range(4) != 0, $urandom_range(65535));
	endfunction

	initial begin
		int ins;
		int outs;
		sb = new();
		idle_pct = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_item(mk(OP_EVAL, 0, 0, 0, 0));
		send_item(mk(OP_WRITE, 0, 0, 0, 32767));
		send_item(mk(OP_WRITE, 63, 0, 0, -32768));
		send_item(mk(OP_APPEND, 0, 1, 1, 32767));
		send_item(mk(OP_APPEND, 63, 2, 1, -32768));
		send_item(mk(OP_APPEND, 0, 3, 0, 4096));
		send_item(mk(OP_APPEND, 63, 63, 1, 100));
		send_item(mk(OP_EVAL, 0, 0, 0, 0));
		write_cfg(CFG_OUTPUT_COUNT, 7'd16);
		send_item(mk(OP_EVAL, 0, 0, 0, 0));
		write_cfg(CFG_OUTPUT_COUNT, 7'd31);
		write_cfg(CFG_INPUT_COUNT, 7'd60);
		send_item(mk(OP_EVAL, 63, 63, 1, 0));
		write_cfg(CFG_INPUT_COUNT, 7'd0);
		send_item(mk(OP_EVAL, 0, 0, 0, 0));
		write_cfg(CFG_INPUT_COUNT, 7'd127);
		write_cfg(CFG_OUTPUT_COUNT, 7'd0);
		send_item(mk(OP_EVAL, 0, 0, 0, 0));
		send_item(mk(OP_CLEAR, 0, 0, 0, 0));
		write_cfg(CFG_INPUT_COUNT, 7'd2);
		write_cfg(CFG_OUTPUT_COUNT, 7'd3);
		for (int i = 0; i < 40; i++)
			send_item(mk(OP_APPEND, i % 3, 2 + i % 3, 1, $urandom_range(65535)));
		send_item(mk(OP_EVAL, 0, 0, 0, 0));
		send_item(mk(OP_CLEAR, 0, 0, 0, 0));

		for (int ph = 0; ph < 5; ph++) begin
			idle_pct = ph == 0 ? 38 : ph == 1 ? 64 : 0;
			ins = ph == 4 ? 64 : $urandom_range(1, 8);
			outs = ph == 3 ? 1 : $urandom_range(1, 16);
			write_cfg(CFG_INPUT_COUNT, 7'(ins));
			write_cfg(CFG_OUTPUT_COUNT, 7'(outs));
			for (int i = 0; i < 20; i++) send_item(rand_item(ins));
			send_item(mk(OP_EVAL, 0, 0, 0, 0));
		end
		drain();

		$display("ran %0d evaluations, %0d results checked, across input/output count settings",
			sb.evals, sb.results_seen);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("** sparse_net_one_step_eval_core: PASSED **");
		end else begin
			$display("** sparse_net_one_step_eval_core: FAILED **");
		end
		$finish;
	end
endmodule
